[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the top-off level protection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge of clk outside reset.
`define ASSERT_PROP(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

[rtl/tolp_pkg.sv]
// Types and constants of the top-off level protection block.
package tolp_pkg;

	localparam int LEVEL_W      = 12;
	localparam int TIME_W       = 48;
	localparam int TIMEOUT_W    = 16;
	localparam int TIMEOUT_MS_W = 26;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam int DEBOUNCE_SAMPLES = 3;
	localparam int FREQ_WINDOW_SEC  = 3600;
	localparam int EMPTY_DETECT_SEC = 60;
	localparam int PERSIST_LOW_SEC  = 300;
	localparam int MS_IN_SEC        = 1000;

	localparam logic [2:0]        DEBOUNCE_CNT    = 3'(DEBOUNCE_SAMPLES);
	localparam logic [TIME_W-1:0] FREQ_WINDOW_MS  = TIME_W'(FREQ_WINDOW_SEC * MS_IN_SEC);
	localparam logic [TIME_W-1:0] EMPTY_DETECT_MS = TIME_W'(EMPTY_DETECT_SEC * MS_IN_SEC);
	localparam logic [TIME_W-1:0] PERSIST_LOW_MS  = TIME_W'(PERSIST_LOW_SEC * MS_IN_SEC);

	// Result state codes
	localparam logic [2:0] ST_NORMAL    = 3'd0;
	localparam logic [2:0] ST_REFILL    = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_BLOCKED   = 3'd3;
	localparam logic [2:0] ST_ERROR     = 3'd4;
	localparam logic [2:0] ST_DISABLED  = 3'd5;

	// Alarm codes
	localparam logic [3:0] ALM_NONE     = 4'd0;
	localparam logic [3:0] ALM_INVALID  = 4'd1;
	localparam logic [3:0] ALM_REFILL   = 4'd2;
	localparam logic [3:0] ALM_TIMEOUT  = 4'd3;
	localparam logic [3:0] ALM_BLOCKED  = 4'd4;
	localparam logic [3:0] ALM_PERSIST  = 4'd5;
	localparam logic [3:0] ALM_OVERFLOW = 4'd6;
	localparam logic [3:0] ALM_FREQ     = 4'd7;
	localparam logic [3:0] ALM_EMPTY    = 4'd8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVF_MARGIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_RISE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX  = 3'd7;

	typedef struct packed {
		logic              cmd;
		logic              sample_ok;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [2:0] ato_state;
		logic       pump_on;
		logic       shutoff;
		logic       shutoff_cause;
		logic [3:0] alarm;
	} result_t;

	typedef struct packed {
		logic                    enable;
		logic [LEVEL_W-1:0]      low_level;
		logic [LEVEL_W-1:0]      high_level;
		logic [LEVEL_W-1:0]      overflow_margin;
		logic [TIMEOUT_MS_W-1:0] timeout_ms;
		logic [LEVEL_W-1:0]      hysteresis_band;
		logic [LEVEL_W-1:0]      empty_min_rise;
		logic [7:0]              refill_count_max;
	} cfg_t;

endpackage

[rtl/tolp_cfg_regs.sv]
// Configuration register file of the top-off level protection block.
module tolp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [tolp_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [tolp_pkg::CFG_DATA_W-1:0]    wr_data,
	output tolp_pkg::cfg_t                     cfg
);
	import tolp_pkg::*;

	cfg_t cfg_q;
	logic [TIMEOUT_MS_W-1:0] timeout_ms;

	// Keep the timeout in milliseconds so the per-item path only compares.
	assign timeout_ms = TIMEOUT_MS_W'(wr_data[TIMEOUT_W-1:0]) * TIMEOUT_MS_W'(MS_IN_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b1;
			cfg_q.low_level        <= LEVEL_W'(1500);
			cfg_q.high_level       <= LEVEL_W'(2500);
			cfg_q.overflow_margin  <= LEVEL_W'(200);
			cfg_q.timeout_ms       <= TIMEOUT_MS_W'(120 * MS_IN_SEC);
			cfg_q.hysteresis_band  <= LEVEL_W'(10);
			cfg_q.empty_min_rise   <= LEVEL_W'(20);
			cfg_q.refill_count_max <= 8'd10;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE:     cfg_q.enable           <= wr_data[0];
				REG_LOW_LEVEL:  cfg_q.low_level        <= wr_data[LEVEL_W-1:0];
				REG_HIGH_LEVEL: cfg_q.high_level       <= wr_data[LEVEL_W-1:0];
				REG_OVF_MARGIN: cfg_q.overflow_margin  <= wr_data[LEVEL_W-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ms       <= timeout_ms;
				REG_HYST_BAND:  cfg_q.hysteresis_band  <= wr_data[LEVEL_W-1:0];
				REG_EMPTY_RISE: cfg_q.empty_min_rise   <= wr_data[LEVEL_W-1:0];
				REG_COUNT_MAX:  cfg_q.refill_count_max <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/tolp_core.sv]
// Per-item decision logic and protection state of the top-off level block.
module tolp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tolp_pkg::sample_t item,
	input  tolp_pkg::cfg_t    cfg,
	output logic              has_result,
	output tolp_pkg::result_t res
);
	import tolp_pkg::*;
	`include "assert_macros.svh"

	logic [2:0]          stable_count_q, n_stable_count;
	logic [LEVEL_W-1:0]  stable_level_q, n_stable_level;
	logic                stable_known_q, n_stable_known;
	logic                blocked_q, n_blocked;
	logic [TIME_W-1:0]   low_start_q, n_low_start;
	logic [TIME_W-1:0]   refill_start_q, n_refill_start;
	logic [LEVEL_W-1:0]  refill_base_q, n_refill_base;
	logic [TIME_W-1:0]   window_start_q, n_window_start;
	logic [7:0]          refill_count_q, n_refill_count;

	logic [LEVEL_W-1:0]  level;
	logic [TIME_W-1:0]   now;
	logic [LEVEL_W-1:0]  sl_cur;
	logic [LEVEL_W-1:0]  diff;
	logic                overflow;
	logic                stable_hit;
	logic [2:0]          cnt_next;
	logic [TIME_W-1:0]   low_start_new;
	logic [TIME_W-1:0]   win_diff;
	logic                win_expire;
	logic [7:0]          rc_base;
	logic [7:0]          rc_new;
	logic [TIME_W-1:0]   ref_diff;
	logic                ref_late;
	logic                timed_out;
	logic                empty_time;
	logic signed [LEVEL_W+1:0] rise;
	logic                rise_short;
	logic [TIME_W-1:0]   low_diff;
	logic                persist_low;

	assign level = item.level;
	assign now   = item.time_ms;

	// Overflow trip threshold carries one extra bit.
	assign overflow = {1'b0, level} > ({1'b0, cfg.high_level} + {1'b0, cfg.overflow_margin});

	// Debounce against the stable level, seeded by the first valid sample.
	assign sl_cur     = stable_known_q ? stable_level_q : level;
	assign diff       = (level >= sl_cur) ? level - sl_cur : sl_cur - level;
	assign stable_hit = diff < cfg.hysteresis_band;
	assign cnt_next   = !stable_hit ? 3'd0 :
		(stable_count_q == 3'd7) ? 3'd7 : stable_count_q + 3'd1;

	// Elapsed times; a time earlier than the start counts as beyond every limit.
	assign low_start_new = (low_start_q == '0) ? now : low_start_q;

	assign win_diff   = now - window_start_q;
	assign win_expire = (window_start_q == '0) || (now < window_start_q) ||
		(win_diff > FREQ_WINDOW_MS);
	assign rc_base    = win_expire ? 8'd0 : refill_count_q;
	assign rc_new     = (rc_base == 8'hff) ? 8'hff : rc_base + 8'd1;

	assign ref_diff   = now - refill_start_q;
	assign ref_late   = now < refill_start_q;
	assign timed_out  = ref_late || (ref_diff > TIME_W'(cfg.timeout_ms));
	assign empty_time = ref_late || (ref_diff >= EMPTY_DETECT_MS);

	assign rise       = $signed({2'b00, level}) - $signed({2'b00, refill_base_q});
	assign rise_short = rise < $signed({2'b00, cfg.empty_min_rise});

	assign low_diff    = now - low_start_new;
	assign persist_low = (now < low_start_new) || (low_diff >= PERSIST_LOW_MS);

	assign has_result = !item.cmd;

	always_comb begin
		n_stable_count = stable_count_q;
		n_stable_level = stable_level_q;
		n_stable_known = stable_known_q;
		n_blocked      = blocked_q;
		n_low_start    = low_start_q;
		n_refill_start = refill_start_q;
		n_refill_base  = refill_base_q;
		n_window_start = window_start_q;
		n_refill_count = refill_count_q;
		res            = '0;
		res.ato_state  = ST_NORMAL;
		res.alarm      = ALM_NONE;

		if (item.cmd) begin
			n_blocked = 1'b0;
		end else if (!cfg.enable) begin
			res.ato_state = ST_DISABLED;
		end else if (!item.sample_ok) begin
			n_stable_count = 3'd0;
			res.ato_state  = ST_ERROR;
			res.alarm      = ALM_INVALID;
		end else begin
			n_stable_known = 1'b1;
			n_stable_level = sl_cur;
			if (overflow) begin
				n_stable_count    = 3'd0;
				n_stable_level    = level;
				n_blocked         = 1'b1;
				res.ato_state     = ST_OVERFLOW;
				res.shutoff       = 1'b1;
				res.shutoff_cause = 1'b1;
				res.alarm         = ALM_OVERFLOW;
			end else if (blocked_q) begin
				n_stable_count    = 3'd0;
				res.ato_state     = ST_BLOCKED;
				res.shutoff       = 1'b1;
				res.shutoff_cause = 1'b1;
				res.alarm         = ALM_BLOCKED;
			end else begin
				n_stable_count = cnt_next;
				n_stable_level = level;
				if (cnt_next >= DEBOUNCE_CNT) begin
					if (level < cfg.low_level) begin
						n_low_start = low_start_new;
						if (refill_start_q == '0) begin
							n_refill_start = now;
							n_refill_base  = level;
							if (win_expire) begin
								n_window_start = now;
							end
							n_refill_count = rc_new;
							res.ato_state  = ST_REFILL;
							res.pump_on    = 1'b1;
							res.alarm      = (rc_new > cfg.refill_count_max) ?
								ALM_FREQ : ALM_REFILL;
						end else if (timed_out) begin
							n_blocked         = 1'b1;
							res.ato_state     = ST_BLOCKED;
							res.shutoff       = 1'b1;
							res.shutoff_cause = 1'b1;
							res.alarm         = ALM_TIMEOUT;
						end else if (empty_time && rise_short) begin
							res.ato_state = ST_ERROR;
							res.alarm     = ALM_EMPTY;
						end else begin
							res.ato_state = ST_REFILL;
							res.pump_on   = 1'b1;
							res.alarm     = persist_low ? ALM_PERSIST : ALM_NONE;
						end
					end else begin
						n_refill_start = '0;
						n_low_start    = '0;
						n_stable_count = 3'd0;
					end
				end else if (!stable_hit) begin
					n_stable_level = level;
				end else begin
					n_stable_level = sl_cur;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_count_q <= 3'd0;
			stable_level_q <= '0;
			stable_known_q <= 1'b0;
			blocked_q      <= 1'b0;
			low_start_q    <= '0;
			refill_start_q <= '0;
			refill_base_q  <= '0;
			window_start_q <= '0;
			refill_count_q <= 8'd0;
		end else if (advance) begin
			stable_count_q <= n_stable_count;
			stable_level_q <= n_stable_level;
			stable_known_q <= n_stable_known;
			blocked_q      <= n_blocked;
			low_start_q    <= n_low_start;
			refill_start_q <= n_refill_start;
			refill_base_q  <= n_refill_base;
			window_start_q <= n_window_start;
			refill_count_q <= n_refill_count;
		end
	end

	`ASSERT_PROP(a_ovf_latches, advance && !item.cmd && cfg.enable && item.sample_ok && overflow |=> blocked_q)
	`ASSERT_PROP(a_clear_releases, advance && item.cmd |=> !blocked_q)
	`ASSERT_NEVER(a_refill_without_low, refill_start_q != '0 && low_start_q == '0)

endmodule

[rtl/top_off_level_protection_fsm.sv]
// Top level of the top-off level protection block: channels, item and result registers.
//
// Use:
//   sample channel (meas_valid / sample_stall / sample) carries one item per
//   handshake: a timestamped level sample (cmd 0) or a clear of the blocked
//   latch (cmd 1). Each sample item yields exactly one result item on the
//   result channel (result_valid / result_stall / result); a clear yields none.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes one
//   register per handshake; cfg_ready is always high. Write only while idle.
// Timing:
//   An accepted item lands in the item register; once the result slot is
//   free or being emptied, the decision logic evaluates it against the
//   protection state and, for a sample, loads the result register, raising result_valid.
//   One item per cycle is sustained while result_stall is low: the item
//   register and the result register each hold one item, and the result
//   register is freed in the same cycle it is taken.
// Reset (arst_n low): registers return to their defaults, all counters and
//   timestamps clear, the blocked latch opens and both channels empty.
// Stall: a stalled result holds in the result register; the item register
//   then holds too, and sample_stall rises while it holds an item.
module top_off_level_protection_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            meas_valid,
	output logic                            sample_stall,
	input  tolp_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output tolp_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tolp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tolp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tolp_pkg::*;
	`include "assert_macros.svh"

	cfg_t    cfg;
	sample_t item_s1;
	logic    item_valid_s1;
	logic    advance;
	logic    accept;
	logic    has_result;
	result_t res;
	result_t result_q;
	logic    result_valid_q;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	tolp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Advance the held item when the result slot is free or being emptied.
	assign advance      = item_valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = item_valid_s1 && !advance;
	assign accept       = meas_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Item payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	tolp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.res        (res)
	);

	// Load a new result, or drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_PROP(a_stall_only_when_full, sample_stall |-> item_valid_s1)
	`ASSERT_PROP(a_pump_only_refill, result_valid && result.pump_on |-> result.ato_state == ST_REFILL)
	`ASSERT_PROP(a_shutoff_cause, result_valid && result.shutoff |-> result.shutoff_cause)

endmodule
